### hw/rtl/scalar_mod_order_alu_unit_macros.svh
// Assertion macros used by the scalar ALU back end.
`ifndef SCALAR_MOD_ORDER_ALU_UNIT_MACROS_SVH
`define SCALAR_MOD_ORDER_ALU_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCMO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCMO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scmo_pkg.sv
`default_nettype none
package scmo_pkg;

    localparam int SCALAR_BITS = 256;
    localparam int LIMB_BITS = 64;
    localparam int CNT_W = $clog2(SCALAR_BITS);
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Group order and the inversion exponent n - 2.
    localparam logic [SCALAR_BITS-1:0] ORDER_N =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
    localparam logic [SCALAR_BITS-1:0] ORDER_M2 =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD036413F;
    localparam logic [SCALAR_BITS-1:0] ONE = 256'd1;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_NEG = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_SQ,
        S_PM,
        S_DONE
    } back_state_t;

    typedef struct packed {
        logic [2:0]             op;
        logic                   bad_op;
        logic                   err;
        logic [SCALAR_BITS-1:0] a;
        logic [SCALAR_BITS-1:0] b;
    } cmd_t;

    typedef struct packed {
        logic                   err;
        logic [SCALAR_BITS-1:0] r;
    } res_t;

    typedef struct packed {
        logic                   start;
        logic [SCALAR_BITS-1:0] x;
        logic [SCALAR_BITS-1:0] y;
    } mul_req_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [SCALAR_BITS-1:0] product;
    } mul_rsp_t;

    function automatic logic below_n(input logic [SCALAR_BITS-1:0] x);
        return x < ORDER_N;
    endfunction

    // Sum of two reduced values, reduced again with one conditional subtract.
    function automatic logic [SCALAR_BITS-1:0] add_mod(
        input logic [SCALAR_BITS-1:0] x,
        input logic [SCALAR_BITS-1:0] y
    );
        logic [SCALAR_BITS:0]   s;
        logic [SCALAR_BITS+1:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = {1'b0, s} - {2'b00, ORDER_N};
        return d[SCALAR_BITS+1] ? s[SCALAR_BITS-1:0] : d[SCALAR_BITS-1:0];
    endfunction

    function automatic logic [SCALAR_BITS-1:0] neg_mod(input logic [SCALAR_BITS-1:0] x);
        return (x == '0) ? '0 : ORDER_N - x;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/scmo_queue.sv
`default_nettype none
module scmo_queue #(
    parameter int DEPTH = 4,
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/scmo_front.sv
`default_nettype none
module scmo_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [2:0]                         action,
    input  wire logic [scmo_pkg::SCALAR_BITS-1:0]   a,
    input  wire logic [scmo_pkg::SCALAR_BITS-1:0]   b,
    output logic                                    cq_push,
    output scmo_pkg::cmd_t                          cq_data,
    input  wire logic                               cq_full
);
    logic           valid_reg, valid_next;
    scmo_pkg::cmd_t stage_reg, stage_next;
    logic           accept;
    logic           uses_b, bad_op;

    assign full    = valid_reg && cq_full;
    assign accept  = push && !full;
    assign cq_push = valid_reg && !cq_full;
    assign cq_data = stage_reg;

    // Classify the incoming item: operand use and range check.
    always_comb
    begin
        uses_b = 1'b0;
        bad_op = 1'b0;
        unique case (action)
            scmo_pkg::OP_ADD, scmo_pkg::OP_SUB, scmo_pkg::OP_MUL: uses_b = 1'b1;
            scmo_pkg::OP_NEG, scmo_pkg::OP_INV:                   uses_b = 1'b0;
            default:                                              bad_op = 1'b1;
        endcase
        stage_next        = stage_reg;
        stage_next.op     = action;
        stage_next.bad_op = bad_op;
        stage_next.a      = a;
        stage_next.b      = b;
        stage_next.err    = !bad_op
            && (!scmo_pkg::below_n(a) || (uses_b && !scmo_pkg::below_n(b)));
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (cq_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/scmo_modmul.sv
`default_nettype none
module scmo_modmul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scmo_pkg::mul_req_t req,
    output scmo_pkg::mul_rsp_t      rsp
);
    localparam int SB = scmo_pkg::SCALAR_BITS;
    localparam int CW = scmo_pkg::CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] acc_reg, acc_next;
    logic [SB-1:0] x_reg, x_next;
    logic [SB-1:0] y_reg, y_next;

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    // Double-and-add, most significant multiplier bit first, one modular add a cycle.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (!busy_reg && req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            acc_next   = '0;
            x_next     = req.x;
            y_next     = req.y;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_next   = scmo_pkg::add_mod(acc_reg, acc_reg);
                phase_next = 1'b1;
            end
            else
            begin
                if (y_reg[SB-1])
                begin
                    acc_next = scmo_pkg::add_mod(acc_reg, x_reg);
                end
                y_next     = {y_reg[SB-2:0], 1'b0};
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SB - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end
endmodule
`default_nettype wire

### hw/rtl/scmo_back.sv
`default_nettype none
`include "scalar_mod_order_alu_unit_macros.svh"
module scmo_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    output logic                    cq_pop,
    input  wire scmo_pkg::cmd_t     cq_data,
    input  wire logic               cq_empty,
    output logic                    oq_push,
    output scmo_pkg::res_t          oq_data,
    input  wire logic               oq_full,
    output scmo_pkg::mul_req_t      mul_req,
    input  wire scmo_pkg::mul_rsp_t mul_rsp
);
    localparam int SB = scmo_pkg::SCALAR_BITS;
    localparam int CW = scmo_pkg::CNT_W;

    scmo_pkg::back_state_t state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic          bad_reg, bad_next;
    logic          err_reg, err_next;
    logic [SB-1:0] a_reg, a_next;
    logic [SB-1:0] b_reg, b_next;
    logic [SB-1:0] res_reg, res_next;
    logic [CW-1:0] ebit_reg, ebit_next;

    assign oq_data.err = err_reg;
    assign oq_data.r   = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scmo_pkg::S_IDLE:
            begin
                if (!cq_empty)
                begin
                    state_next = scmo_pkg::S_EXEC;
                end
            end
            scmo_pkg::S_EXEC:
            begin
                if (err_reg || bad_reg)
                begin
                    state_next = scmo_pkg::S_DONE;
                end
                else
                begin
                    unique case (op_reg)
                        scmo_pkg::OP_SUB: state_next = scmo_pkg::S_EXEC;
                        scmo_pkg::OP_MUL: state_next = scmo_pkg::S_MUL;
                        scmo_pkg::OP_INV:
                            state_next = (a_reg == '0) ? scmo_pkg::S_DONE : scmo_pkg::S_SQ;
                        default:          state_next = scmo_pkg::S_DONE;
                    endcase
                end
            end
            scmo_pkg::S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = scmo_pkg::S_DONE;
                end
            end
            scmo_pkg::S_SQ:
            begin
                if (mul_rsp.done)
                begin
                    if (scmo_pkg::ORDER_M2[ebit_reg])
                    begin
                        state_next = scmo_pkg::S_PM;
                    end
                    else if (ebit_reg == '0)
                    begin
                        state_next = scmo_pkg::S_DONE;
                    end
                end
            end
            scmo_pkg::S_PM:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (ebit_reg == '0) ? scmo_pkg::S_DONE : scmo_pkg::S_SQ;
                end
            end
            scmo_pkg::S_DONE:
            begin
                if (!oq_full)
                begin
                    state_next = scmo_pkg::S_IDLE;
                end
            end
            default: state_next = scmo_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        cq_pop      = 1'b0;
        oq_push     = 1'b0;
        mul_req     = '0;
        op_next     = op_reg;
        bad_next    = bad_reg;
        err_next    = err_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        ebit_next   = ebit_reg;
        unique case (state_reg)
            scmo_pkg::S_IDLE:
            begin
                cq_pop = !cq_empty;
                if (!cq_empty)
                begin
                    op_next  = cq_data.op;
                    bad_next = cq_data.bad_op;
                    err_next = cq_data.err;
                    a_next   = cq_data.a;
                    b_next   = cq_data.b;
                end
            end
            scmo_pkg::S_EXEC:
            begin
                res_next = '0;
                if (!err_reg && !bad_reg)
                begin
                    unique case (op_reg)
                        scmo_pkg::OP_ADD: res_next = scmo_pkg::add_mod(a_reg, b_reg);
                        scmo_pkg::OP_SUB:
                        begin
                            // Subtract runs as an add of the negated operand.
                            b_next  = scmo_pkg::neg_mod(b_reg);
                            op_next = scmo_pkg::OP_ADD;
                        end
                        scmo_pkg::OP_MUL:
                        begin
                            mul_req.start = 1'b1;
                            mul_req.x     = a_reg;
                            mul_req.y     = b_reg;
                        end
                        scmo_pkg::OP_NEG: res_next = scmo_pkg::neg_mod(a_reg);
                        scmo_pkg::OP_INV:
                        begin
                            // The first squaring of the accumulator starts from one.
                            ebit_next     = CW'(SB - 1);
                            mul_req.start = (a_reg != '0);
                            mul_req.x     = scmo_pkg::ONE;
                            mul_req.y     = scmo_pkg::ONE;
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            scmo_pkg::S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    res_next = mul_rsp.product;
                end
            end
            scmo_pkg::S_SQ:
            begin
                if (mul_rsp.done)
                begin
                    res_next = mul_rsp.product;
                    if (scmo_pkg::ORDER_M2[ebit_reg])
                    begin
                        mul_req.start = 1'b1;
                        mul_req.x     = mul_rsp.product;
                        mul_req.y     = a_reg;
                    end
                    else if (ebit_reg != '0)
                    begin
                        ebit_next     = ebit_reg - 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.x     = mul_rsp.product;
                        mul_req.y     = mul_rsp.product;
                    end
                end
            end
            scmo_pkg::S_PM:
            begin
                if (mul_rsp.done)
                begin
                    res_next = mul_rsp.product;
                    if (ebit_reg != '0)
                    begin
                        ebit_next     = ebit_reg - 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.x     = mul_rsp.product;
                        mul_req.y     = mul_rsp.product;
                    end
                end
            end
            scmo_pkg::S_DONE:
            begin
                oq_push = !oq_full;
            end
            default: oq_push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scmo_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        bad_reg  <= bad_next;
        err_reg  <= err_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        ebit_reg <= ebit_next;
    end

    // A rejected item must leave as zero.
    `SCMO_ASSERT_NOW(a_err_zero, oq_push && err_reg, res_reg == '0, "error item with nonzero result")
    // The multiplier is only started while it is free.
    `SCMO_ASSERT_NOW(a_mul_free, mul_req.start, !mul_rsp.busy, "multiply started while busy")
    // The exponent position holds while a product is under way.
    `SCMO_ASSERT_NEXT(a_ebit_hold, mul_rsp.busy && !mul_req.start, $stable(ebit_reg),
        "exponent bit moved during a product")
endmodule
`default_nettype wire

### hw/rtl/scalar_mod_order_alu_unit.sv
// Path: an add, negate, out-of-range or unused-code item passes the front stage register, the command
// queue, and the back end's idle, execute and done states; subtract passes the execute state twice.
// Multiply waits in the back end for the serial multiplier (two modular adds per multiplier bit).
// Invert runs 256 squarings plus one product per set bit of n-2, each in the serial multiplier.
// The back end takes a new item only after its last result is pushed; multiply and invert hold it.
// Reset: rst_n is asynchronous and active low; it empties both queues and idles the back end.
`default_nettype none
module scalar_mod_order_alu_unit #(
    parameter int CMD_DEPTH = scmo_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = scmo_pkg::OUT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  action,
    input  wire logic [63:0] a_limb0,
    input  wire logic [63:0] a_limb1,
    input  wire logic [63:0] a_limb2,
    input  wire logic [63:0] a_limb3,
    input  wire logic [63:0] b_limb0,
    input  wire logic [63:0] b_limb1,
    input  wire logic [63:0] b_limb2,
    input  wire logic [63:0] b_limb3,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      r_limb0,
    output logic [63:0]      r_limb1,
    output logic [63:0]      r_limb2,
    output logic [63:0]      r_limb3,
    output logic             range_error
);
    localparam int CMD_W = $bits(scmo_pkg::cmd_t);
    localparam int RES_W = $bits(scmo_pkg::res_t);

    logic                   cq_push, cq_full, cq_pop, cq_empty;
    scmo_pkg::cmd_t         cq_wdata, cq_rdata;
    logic                   oq_push, oq_full;
    scmo_pkg::res_t         oq_wdata, oq_rdata;
    scmo_pkg::mul_req_t     mul_req;
    scmo_pkg::mul_rsp_t     mul_rsp;

    // Front end: take and classify items.
    scmo_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .action  (action),
        .a       ({a_limb3, a_limb2, a_limb1, a_limb0}),
        .b       ({b_limb3, b_limb2, b_limb1, b_limb0}),
        .cq_push (cq_push),
        .cq_data (cq_wdata),
        .cq_full (cq_full)
    );

    // Command queue between front and back.
    scmo_queue #(.DEPTH(CMD_DEPTH), .W(CMD_W)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wdata),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    // Back end: sequencer and modular datapath.
    scmo_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_pop   (cq_pop),
        .cq_data  (cq_rdata),
        .cq_empty (cq_empty),
        .oq_push  (oq_push),
        .oq_data  (oq_wdata),
        .oq_full  (oq_full),
        .mul_req  (mul_req),
        .mul_rsp  (mul_rsp)
    );

    scmo_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Result queue towards the consumer.
    scmo_queue #(.DEPTH(OUT_DEPTH), .W(RES_W)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign r_limb0     = oq_rdata.r[63:0];
    assign r_limb1     = oq_rdata.r[127:64];
    assign r_limb2     = oq_rdata.r[191:128];
    assign r_limb3     = oq_rdata.r[255:192];
    assign range_error = oq_rdata.err;
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    // Codes outside the operation set; the block answers them with zero.
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam logic [255:0] ALL_ONES = '1;
    localparam logic [255:0] N_M1 = scmo_pkg::ORDER_N - 256'd1;
    localparam int IDLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [255:0] r;
        logic         err;
    } scalar_res_t;

    typedef struct {
        logic [2:0]   op;
        logic [255:0] a;
        logic [255:0] b;
        bit           typed;
        scalar_res_t  res;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         push = 1'b0;
    logic         pop = 1'b0;
    logic [2:0]   action = scmo_pkg::OP_ADD;
    logic [255:0] opa = '0;
    logic [255:0] opb = '0;
    wire          full;
    wire          empty;
    wire  [63:0]  r_limb0, r_limb1, r_limb2, r_limb3;
    wire          range_error;

    scalar_res_t  pending_q[$];
    int           errors = 0;
    bit           hold_req = 1'b0;
    bit           stim_done = 1'b0;

    scalar_mod_order_alu_unit DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .a_limb0(opa[63:0]), .a_limb1(opa[127:64]),
        .a_limb2(opa[191:128]), .a_limb3(opa[255:192]),
        .b_limb0(opb[63:0]), .b_limb1(opb[127:64]),
        .b_limb2(opb[191:128]), .b_limb3(opb[255:192]),
        .empty(empty), .pop(pop),
        .r_limb0(r_limb0), .r_limb1(r_limb1), .r_limb2(r_limb2), .r_limb3(r_limb3),
        .range_error(range_error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Modular product through a double-width intermediate.
    function automatic logic [255:0] mulmod_n(input logic [255:0] x, input logic [255:0] y);
        logic [511:0] p;
        p = {256'd0, x} * {256'd0, y};
        return 256'(p % {256'd0, scmo_pkg::ORDER_N});
    endfunction

    function automatic logic [255:0] addmod_n(input logic [255:0] x, input logic [255:0] y);
        logic [256:0] s;
        s = {1'b0, x} + {1'b0, y};
        return 256'(s % {1'b0, scmo_pkg::ORDER_N});
    endfunction

    function automatic logic [255:0] negmod_n(input logic [255:0] x);
        return (x == '0) ? '0 : scmo_pkg::ORDER_N - x;
    endfunction

    // Fermat inverse, a^(n-2), with zero mapped to zero.
    function automatic logic [255:0] invmod_n(input logic [255:0] x);
        logic [255:0] acc;
        logic [255:0] ex;
        acc = 256'd1;
        ex = scmo_pkg::ORDER_N - 256'd2;
        if (x == '0)
        begin
            return '0;
        end
        for (int i = 255; i >= 0; i--)
        begin
            acc = mulmod_n(acc, acc);
            if (ex[i])
            begin
                acc = mulmod_n(acc, x);
            end
        end
        return acc;
    endfunction

    function automatic scalar_res_t predict_scalar(input logic [2:0] op, input logic [255:0] a,
                                                   input logic [255:0] b);
        scalar_res_t res;
        bit uses_b;
        res = '0;
        uses_b = (op == scmo_pkg::OP_ADD) || (op == scmo_pkg::OP_SUB)
            || (op == scmo_pkg::OP_MUL);
        if (op > scmo_pkg::OP_INV)
        begin
            return res;
        end
        if (a >= scmo_pkg::ORDER_N || (uses_b && b >= scmo_pkg::ORDER_N))
        begin
            res.err = 1'b1;
            return res;
        end
        case (op)
            scmo_pkg::OP_ADD: res.r = addmod_n(a, b);
            scmo_pkg::OP_SUB: res.r = addmod_n(a, negmod_n(b));
            scmo_pkg::OP_MUL: res.r = mulmod_n(a, b);
            scmo_pkg::OP_NEG: res.r = negmod_n(a);
            default: res.r = invmod_n(a);
        endcase
        return res;
    endfunction

    // Offers one item from the current posedge and waits until it is taken.
    task automatic offer_item(input logic [2:0] op, input logic [255:0] a, input logic [255:0] b,
                              input scalar_res_t res);
        bit taken;
        push <= 1'b1;
        action <= op;
        opa <= a;
        opb <= b;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end while (!taken);
        pending_q.insert(pending_q.size(), res);
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Operands biased towards zero, small values, and both sides of n.
    function automatic logic [255:0] pick_scalar();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return '0;
            1, 2: return 256'($urandom_range(1, 1000));
            3, 4: return N_M1 - 256'($urandom_range(0, 1000));
            5: return scmo_pkg::ORDER_N + 256'($urandom_range(0, 3));
            6: return ALL_ONES - 256'($urandom_range(0, 3));
            default: return {$urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // Receiver: a repeating pattern of pops and stalls, with a long hold on request.
    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                cyc++;
                if ((cyc % 96) < 32)
                    pop <= 1'b1;
                else if ((cyc % 96) < 64)
                    pop <= ($urandom_range(0, 3) != 0);
                else
                    pop <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Result checker: values are stable from the falling edge up to the taking edge.
    always @(negedge clk)
    begin
        scalar_res_t want;
        logic [255:0] got;
        if (rst_n && pop && !empty)
        begin
            got = {r_limb3, r_limb2, r_limb1, r_limb0};
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected item r=%h err=%b", $time, got, range_error);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got !== want.r)
                begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want.r, got);
                    errors++;
                end
                if (range_error !== want.err)
                begin
                    $display("%0t: range_error mismatch expected %b actual %b",
                             $time, want.err, range_error);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random bursts.
    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        scalar_res_t res;
        logic [2:0] op;
        logic [255:0] a, b;
        int burst, sel;

        // Directed rows: extremes, out-of-range operands, zero shortcuts, unused codes.
        rows = '{
            '{scmo_pkg::OP_ADD, '0, '0, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_ADD, N_M1, 256'd1, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_ADD, N_M1, N_M1, 1, '{scmo_pkg::ORDER_N - 256'd2, 1'b0}},
            '{scmo_pkg::OP_ADD, scmo_pkg::ORDER_N, '0, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_ADD, '0, scmo_pkg::ORDER_N, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_ADD, ALL_ONES, '0, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_SUB, '0, '0, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_SUB, '0, 256'd1, 1, '{N_M1, 1'b0}},
            '{scmo_pkg::OP_SUB, 256'd5, 256'd5, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_SUB, 256'd1, scmo_pkg::ORDER_N, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_MUL, '0, N_M1, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_MUL, N_M1, N_M1, 1, '{256'd1, 1'b0}},
            '{scmo_pkg::OP_MUL, 256'd2, 256'd3, 1, '{256'd6, 1'b0}},
            '{scmo_pkg::OP_MUL, scmo_pkg::ORDER_N, 256'd1, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_MUL, ALL_ONES >> 1, N_M1 >> 3, 0, '{'0, 1'b0}},
            '{scmo_pkg::OP_NEG, '0, '0, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_NEG, 256'd1, '0, 1, '{N_M1, 1'b0}},
            '{scmo_pkg::OP_NEG, N_M1, '0, 1, '{256'd1, 1'b0}},
            '{scmo_pkg::OP_NEG, scmo_pkg::ORDER_N, ALL_ONES, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_NEG, 256'd5, ALL_ONES, 1, '{scmo_pkg::ORDER_N - 256'd5, 1'b0}},
            '{scmo_pkg::OP_INV, '0, '0, 1, '{'0, 1'b0}},
            '{scmo_pkg::OP_INV, scmo_pkg::ORDER_N, '0, 1, '{'0, 1'b1}},
            '{scmo_pkg::OP_INV, 256'd1, ALL_ONES, 1, '{256'd1, 1'b0}},
            '{ACT_RSVD5, 256'd7, 256'd9, 1, '{'0, 1'b0}},
            '{ACT_RSVD6, ALL_ONES, ALL_ONES, 1, '{'0, 1'b0}},
            '{ACT_RSVD7, N_M1, '0, 1, '{'0, 1'b0}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            res = row.typed ? row.res : predict_scalar(row.op, row.a, row.b);
            offer_item(row.op, row.a, row.b, res);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 4));
        end

        // Let the directed items drain before the random part.
        idle_sender(1);
        wait (pending_q.size() == 0);
        @(posedge clk);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Long receiver hold while a back-to-back run of fast items fills the block.
            if (n == 300)
            begin
                hold_req = 1'b1;
                for (int k = 0; k < 40; k++)
                begin
                    a = pick_scalar();
                    b = pick_scalar();
                    offer_item(scmo_pkg::OP_ADD, a, b,
                               predict_scalar(scmo_pkg::OP_ADD, a, b));
                end
            end
            // Sender waits for every outstanding result.
            if (n == 1200)
            begin
                idle_sender(1);
                wait (pending_q.size() == 0);
                @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            if (n == 900)
                op = scmo_pkg::OP_INV;
            else if (sel < 8)
                op = scmo_pkg::OP_MUL;
            else if (sel < 38)
                op = scmo_pkg::OP_ADD;
            else if (sel < 70)
                op = scmo_pkg::OP_SUB;
            else if (sel < 97)
                op = scmo_pkg::OP_NEG;
            else
                op = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
            a = pick_scalar();
            b = pick_scalar();
            if (n == 900 && a >= scmo_pkg::ORDER_N)
                a = a - scmo_pkg::ORDER_N;
            offer_item(op, a, b, predict_scalar(op, a, b));
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            else
            begin
                burst--;
            end
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // End of run: drain, allow a little latency margin, then report.
    initial
    begin
        wait (stim_done);
        wait (pending_q.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### scalar_mod_order_alu_unit.f
+incdir+hw/rtl
hw/rtl/scmo_pkg.sv
hw/rtl/scmo_queue.sv
hw/rtl/scmo_front.sv
hw/rtl/scmo_modmul.sv
hw/rtl/scmo_back.sv
hw/rtl/scalar_mod_order_alu_unit.sv
tb/sv/testbench.sv
